// ===== hdl/hlsc_pkg.sv =====
package hlsc_pkg;

  // Channel and result widths.
  localparam int unsigned CH_W  = 8;
  localparam int unsigned HUE_W = 9;

  // Divider geometry shared by the saturation and hue quotients.
  // Both numerators fit in 18 bits and both divisors in 10 bits;
  // both quotients stay below 512.
  localparam int unsigned DIV_NUM_W = 18;
  localparam int unsigned DIV_DEN_W = 10;
  localparam int unsigned DIV_Q_W   = 9;

  // Numerator scale factors: saturation is 255*delta/den with half-up
  // rounding, written as (510*delta + den) / (2*den). Hue is 60*h/delta,
  // written as (120*h + delta) / (2*delta).
  localparam int unsigned SAT_SCALE = 510;
  localparam int unsigned HUE_SCALE = 120;

endpackage

// ===== hdl/hlsc_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, Q_W stages.
// The quotient must be known to fit in Q_W bits.
module hlsc_div
  import hlsc_pkg::*;
#(
  parameter int unsigned NUM_W = DIV_NUM_W,
  parameter int unsigned DEN_W = DIV_DEN_W,
  parameter int unsigned Q_W   = DIV_Q_W
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o
);

  localparam int unsigned REM_W = DEN_W + Q_W;

  logic [REM_W-1:0] rem_in  [Q_W];
  logic [DEN_W-1:0] den_in  [Q_W];
  logic [Q_W-1:0]   quo_in  [Q_W];
  logic [REM_W-1:0] rem_d   [Q_W];
  logic [Q_W-1:0]   quo_d   [Q_W];
  logic [REM_W-1:0] rem_q   [Q_W];
  logic [DEN_W-1:0] den_q   [Q_W];
  logic [Q_W-1:0]   quo_q   [Q_W];

  for (genvar gi = 0; gi < Q_W; gi++) begin : g_stage
    logic [REM_W-1:0] trial;
    logic             fits;

    // Each stage takes its operands from the stage before it.
    if (gi == 0) begin : g_first
      assign rem_in[gi] = REM_W'(num_i);
      assign den_in[gi] = den_i;
      assign quo_in[gi] = '0;
    end else begin : g_next
      assign rem_in[gi] = rem_q[gi-1];
      assign den_in[gi] = den_q[gi-1];
      assign quo_in[gi] = quo_q[gi-1];
    end

    // Try to subtract the divisor at this bit's weight.
    assign trial       = REM_W'(den_in[gi]) << (Q_W - 1 - gi);
    assign fits        = (rem_in[gi] >= trial);
    assign rem_d[gi]   = fits ? (rem_in[gi] - trial) : rem_in[gi];
    assign quo_d[gi]   = (quo_in[gi] << 1) | Q_W'(fits);

    always_ff @(posedge clk_i) begin
      rem_q[gi] <= rem_d[gi];
      den_q[gi] <= den_in[gi];
      quo_q[gi] <= quo_d[gi];
    end
  end

  assign quo_o = quo_q[Q_W-1];

endmodule

// ===== hdl/rgb_to_hls_converter_core.sv =====
// RGB to HSL converter for 8-bit pixels.
// Input channel: red_i, green_i and blue_i are taken on each rising edge
// at which start_i is high and busy_o is low. busy_o is always low, so a
// new pixel may be offered in every cycle.
// Result channel: done_o is high for exactly one cycle per pixel, and
// hue_o, lightness_o, saturation_o and achromatic_o are valid in that
// cycle only. The receiver cannot hold a result off.
// Pipeline: from the transfer edge of a pixel to its done_o cycle it passes
// three front stages (max/min, sector offset, numerators), nine divider
// stages, and the output register.
// Throughput: one pixel per cycle; the saturation and hue dividers each
// resolve one quotient bit per stage, which sets the depth.
// Results come out in the order the pixels went in.
// A gray pixel gives achromatic_o high with hue_o and saturation_o zero.
// Reset clears all valid bits, so no stray done_o follows reset; pixels in
// flight at reset are dropped.
module rgb_to_hls_converter_core
  import hlsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [CH_W-1:0]  red_i,
  input  logic [CH_W-1:0]  green_i,
  input  logic [CH_W-1:0]  blue_i,
  output logic             done_o,
  output logic [HUE_W-1:0] hue_o,
  output logic [CH_W-1:0]  lightness_o,
  output logic [CH_W-1:0]  saturation_o,
  output logic             achromatic_o
);

  localparam int unsigned LATENCY = 4 + DIV_Q_W;
  localparam int unsigned SUM_W   = CH_W + 1;
  localparam int unsigned HP_W    = CH_W + 3;

  // Hue sector; the red sector with a negative angle wraps by a full turn.
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2,
    SEC_WRAP  = 2'd3
  } sector_e;

  logic accept;

  // The block never pushes back.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Stage 1: maximum, minimum, sector and signed channel difference.
  logic [CH_W-1:0]   s1_mx_d, s1_mn_d;
  sector_e           s1_sec_d;
  logic signed [CH_W:0] s1_num_d;
  logic              s1_v_q;
  logic [CH_W-1:0]   s1_mx_q, s1_mn_q;
  sector_e           s1_sec_q;
  logic signed [CH_W:0] s1_num_q;

  always_comb begin
    s1_mx_d = red_i;
    s1_mn_d = red_i;
    if (green_i > s1_mx_d) s1_mx_d = green_i;
    if (blue_i > s1_mx_d)  s1_mx_d = blue_i;
    if (green_i < s1_mn_d) s1_mn_d = green_i;
    if (blue_i < s1_mn_d)  s1_mn_d = blue_i;
    // Ties on the maximum go to red, then green.
    if (red_i == s1_mx_d) begin
      s1_num_d = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
      s1_sec_d = (green_i < blue_i) ? SEC_WRAP : SEC_RED;
    end else if (green_i == s1_mx_d) begin
      s1_num_d = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
      s1_sec_d = SEC_GREEN;
    end else begin
      s1_num_d = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
      s1_sec_d = SEC_BLUE;
    end
  end

  // Stage 2: sum, spread, lightness, saturation divisor, hue in sixths.
  logic [SUM_W-1:0]  s2_sum_d;
  logic [CH_W-1:0]   s2_delta_d;
  logic [HP_W-1:0]   s2_base_d;
  logic signed [HP_W:0] s2_hp_full;
  logic              s2_v_q;
  logic [CH_W-1:0]   s2_delta_q;
  logic [CH_W-1:0]   s2_light_q;
  logic [SUM_W-1:0]  s2_den_q;
  logic [HP_W-1:0]   s2_hp_q;
  logic              s2_achrom_q;

  assign s2_sum_d   = SUM_W'(s1_mx_q) + SUM_W'(s1_mn_q);
  assign s2_delta_d = s1_mx_q - s1_mn_q;

  // Sector offset in multiples of the spread: 0, 2, 4 or 6.
  always_comb begin
    case (s1_sec_q)
      SEC_RED:   s2_base_d = '0;
      SEC_GREEN: s2_base_d = HP_W'(s2_delta_d) << 1;
      SEC_BLUE:  s2_base_d = HP_W'(s2_delta_d) << 2;
      SEC_WRAP:  s2_base_d = (HP_W'(s2_delta_d) << 2) + (HP_W'(s2_delta_d) << 1);
      default:   s2_base_d = '0;
    endcase
  end

  assign s2_hp_full = $signed({1'b0, s2_base_d})
                    + $signed({{(HP_W - CH_W){s1_num_q[CH_W]}}, s1_num_q});

  // Stage 3: divider operands.
  logic              s3_v_q;
  logic [CH_W-1:0]   s3_light_q;
  logic              s3_achrom_q;
  logic [DIV_NUM_W-1:0] s3_sat_num_q, s3_hue_num_q;
  logic [DIV_DEN_W-1:0] s3_sat_den_q, s3_hue_den_q;

  // Control: valid bits of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // Payload of the front stages.
  always_ff @(posedge clk_i) begin
    s1_mx_q     <= s1_mx_d;
    s1_mn_q     <= s1_mn_d;
    s1_sec_q    <= s1_sec_d;
    s1_num_q    <= s1_num_d;

    s2_delta_q  <= s2_delta_d;
    s2_light_q  <= s2_sum_d[SUM_W-1:1];
    // Below half lightness the divisor is the sum, otherwise 511 - sum.
    s2_den_q    <= s2_sum_d[SUM_W-1] ? ~s2_sum_d : s2_sum_d;
    s2_hp_q     <= s2_hp_full[HP_W-1:0];
    s2_achrom_q <= (s2_delta_d == '0);

    s3_light_q   <= s2_light_q;
    s3_achrom_q  <= s2_achrom_q;
    s3_sat_num_q <= DIV_NUM_W'(s2_delta_q) * DIV_NUM_W'(SAT_SCALE)
                  + DIV_NUM_W'(s2_den_q);
    s3_sat_den_q <= DIV_DEN_W'({s2_den_q, 1'b0});
    s3_hue_num_q <= DIV_NUM_W'(s2_hp_q) * DIV_NUM_W'(HUE_SCALE)
                  + DIV_NUM_W'(s2_delta_q);
    s3_hue_den_q <= DIV_DEN_W'({s2_delta_q, 1'b0});
  end

  // Dividers. A zero divisor only occurs for gray pixels, whose quotients
  // are discarded at the output.
  logic [DIV_Q_W-1:0] sat_quo, hue_quo;

  hlsc_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .Q_W   (DIV_Q_W)
  ) u_sat_div (
    .clk_i (clk_i),
    .num_i (s3_sat_num_q),
    .den_i (s3_sat_den_q),
    .quo_o (sat_quo)
  );

  hlsc_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .Q_W   (DIV_Q_W)
  ) u_hue_div (
    .clk_i (clk_i),
    .num_i (s3_hue_num_q),
    .den_i (s3_hue_den_q),
    .quo_o (hue_quo)
  );

  // Side line that carries valid, lightness and the gray flag alongside
  // the divider stages.
  logic              side_v_q      [DIV_Q_W];
  logic [CH_W-1:0]   side_light_q  [DIV_Q_W];
  logic              side_achrom_q [DIV_Q_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_Q_W; i++) begin
        side_v_q[i] <= 1'b0;
      end
    end else begin
      side_v_q[0] <= s3_v_q;
      for (int i = 1; i < DIV_Q_W; i++) begin
        side_v_q[i] <= side_v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_light_q[0]  <= s3_light_q;
    side_achrom_q[0] <= s3_achrom_q;
    for (int i = 1; i < DIV_Q_W; i++) begin
      side_light_q[i]  <= side_light_q[i-1];
      side_achrom_q[i] <= side_achrom_q[i-1];
    end
  end

  // Output register.
  logic             done_q;
  logic [HUE_W-1:0] hue_q;
  logic [CH_W-1:0]  light_q;
  logic [CH_W-1:0]  sat_q;
  logic             achrom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= side_v_q[DIV_Q_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    light_q  <= side_light_q[DIV_Q_W-1];
    achrom_q <= side_achrom_q[DIV_Q_W-1];
    hue_q    <= side_achrom_q[DIV_Q_W-1] ? '0 : HUE_W'(hue_quo);
    sat_q    <= side_achrom_q[DIV_Q_W-1] ? '0 : sat_quo[CH_W-1:0];
  end

  assign done_o       = done_q;
  assign hue_o        = hue_q;
  assign lightness_o  = light_q;
  assign saturation_o = sat_q;
  assign achromatic_o = achrom_q;

`ifndef ASSERT_OFF
  // Every transferred pixel yields exactly one strobe after the latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("pixel transfer did not produce a result strobe");

  // A strobe always traces back to a pixel transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result strobe without a matching pixel transfer");

  // The saturation quotient never needs clamping.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (side_v_q[DIV_Q_W-1] && !side_achrom_q[DIV_Q_W-1])
      |-> (sat_quo[DIV_Q_W-1:CH_W] == '0))
    else $error("saturation quotient exceeds 255");

  // Hue stays within a full turn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !achromatic_o) |-> (hue_o <= HUE_W'(360)))
    else $error("hue above 360 degrees");
`endif

endmodule

// ===== test/rgb_to_hls_converter_core_tb.sv =====
module rgb_to_hls_converter_core_tb
  import hlsc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RESET_CYCLES   = 4;
  localparam int unsigned PIPE_LATENCY   = 13;
  localparam int unsigned DRAIN_CYCLES   = 2 * PIPE_LATENCY;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned MAX_GAP        = 4;
  localparam int unsigned GAP_PERCENT    = 4;

  // One converted pixel as it appears on the result ports.
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  lightness;
    logic [CH_W-1:0]  saturation;
    logic             achromatic;
  } hls_pixel_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [CH_W-1:0]  red_i;
  logic [CH_W-1:0]  green_i;
  logic [CH_W-1:0]  blue_i;
  logic             done_o;
  logic [HUE_W-1:0] hue_o;
  logic [CH_W-1:0]  lightness_o;
  logic [CH_W-1:0]  saturation_o;
  logic             achromatic_o;

  hls_pixel_t pending_hls[$];
  int         mismatch_count;
  int         quiet_cycles;
  bit         gaps_on;

  rgb_to_hls_converter_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .done_o       (done_o),
    .hue_o        (hue_o),
    .lightness_o  (lightness_o),
    .saturation_o (saturation_o),
    .achromatic_o (achromatic_o)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Expected HSL values of one pixel, in exact integer arithmetic with
  // half-up rounding of the saturation and hue quotients.
  function automatic hls_pixel_t convert_pixel(input logic [CH_W-1:0] r,
                                               input logic [CH_W-1:0] g,
                                               input logic [CH_W-1:0] b);
    hls_pixel_t px;
    int         rr, gg, bb, hi, lo, sum, delta, den, sat, sector, diff, angle, hue;
    rr = r;
    gg = g;
    bb = b;
    hi = rr;
    lo = rr;
    if (gg > hi) hi = gg;
    if (bb > hi) hi = bb;
    if (gg < lo) lo = gg;
    if (bb < lo) lo = bb;
    sum = hi + lo;
    px.lightness = CH_W'(sum / 2);
    // A gray pixel has no hue and no saturation.
    if (hi == lo) begin
      px.hue        = '0;
      px.saturation = '0;
      px.achromatic = 1'b1;
      return px;
    end
    delta = hi - lo;
    den   = (sum / 2 < 128) ? sum : (511 - sum);
    sat   = (510 * delta + den) / (2 * den);
    if (sat > 255) sat = 255;
    // The sector follows the largest channel; red wins ties, then green.
    if (rr == hi) begin
      sector = 0;
      diff   = gg - bb;
    end else if (gg == hi) begin
      sector = 2;
      diff   = bb - rr;
    end else begin
      sector = 4;
      diff   = rr - gg;
    end
    // Negative angles in the red sector wrap around by a full turn.
    angle = 60 * (sector * delta + diff);
    if (angle < 0) angle += 360 * delta;
    hue = (2 * angle + delta) / (2 * delta);
    px.hue        = HUE_W'(hue);
    px.saturation = CH_W'(sat);
    px.achromatic = 1'b0;
    return px;
  endfunction

  // Offers one pixel, optionally after a short idle gap, and records its
  // expected conversion at the transfer edge. Called and returns at a
  // falling edge.
  task automatic send_pixel(input logic [CH_W-1:0] r,
                            input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b);
    int gap;
    if (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      gap = $urandom_range(MAX_GAP, 1);
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    red_i   <= r;
    green_i <= g;
    blue_i  <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_hls.push_back(convert_pixel(r, g, b));
    @(negedge clk_i);
  endtask

  // Gray pixels across the range, including both extremes and the
  // lightness boundary.
  task automatic test_gray_pixels();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd127, 8'd127, 8'd127);
    send_pixel(8'd1, 8'd1, 8'd1);
  endtask

  // Pure primaries and secondaries at full scale.
  task automatic test_primaries();
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
  endtask

  // Two channels sharing the maximum, to check the sector priority.
  task automatic test_shared_maximum();
    send_pixel(8'd200, 8'd200, 8'd50);
    send_pixel(8'd50, 8'd200, 8'd200);
    send_pixel(8'd200, 8'd50, 8'd200);
  endtask

  // Red-sector pixels with a slightly negative angle, including the ones
  // that round up to a full turn.
  task automatic test_hue_wrap();
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd2);
    send_pixel(8'd100, 8'd0, 8'd1);
    send_pixel(8'd2, 8'd0, 8'd1);
  endtask

  // Pixels on both sides of the lightness split of the saturation divisor.
  task automatic test_lightness_split();
    send_pixel(8'd254, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd254, 8'd254);
  endtask

  // Random pixels, weighted toward gray pixels, shared maxima and
  // full-scale channels.
  task automatic test_random_pixels(input int count, input bit with_gaps);
    logic [CH_W-1:0] r, g, b;
    int              kind;
    gaps_on = with_gaps;
    repeat (count) begin
      r    = CH_W'($urandom);
      g    = CH_W'($urandom);
      b    = CH_W'($urandom);
      kind = $urandom_range(99);
      if (kind < 8) begin
        g = r;
        b = r;
      end else if (kind < 16) begin
        case ($urandom_range(2))
          0: g = r;
          1: b = g;
          default: r = b;
        endcase
      end else if (kind < 22) begin
        r = $urandom_range(1) ? 8'd255 : 8'd0;
        if ($urandom_range(1)) b = $urandom_range(1) ? 8'd255 : 8'd0;
      end
      send_pixel(r, g, b);
    end
    gaps_on = 1'b0;
  endtask

  // Reports one field that differs from its expected value.
  task automatic report_field(input string field, input int expected, input int actual);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
    mismatch_count++;
  endtask

  // Each result transfer is checked against the oldest expected pixel.
  always @(posedge clk_i) begin
    hls_pixel_t want;
    if (rst_ni && done_o) begin
      if (pending_hls.size() == 0) begin
        $display("%0t: result with none expected, hue %0d lightness %0d saturation %0d",
                 $time, hue_o, lightness_o, saturation_o);
        mismatch_count++;
      end else begin
        want = pending_hls.pop_front();
        if (hue_o !== want.hue) report_field("hue", want.hue, hue_o);
        if (lightness_o !== want.lightness)
          report_field("lightness", want.lightness, lightness_o);
        if (saturation_o !== want.saturation)
          report_field("saturation", want.saturation, saturation_o);
        if (achromatic_o !== want.achromatic)
          report_field("achromatic", want.achromatic, achromatic_o);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[rgb_to_hls_converter_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset, directed pixels, random pixels, then drain and verdict.
  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    red_i          = '0;
    green_i        = '0;
    blue_i         = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    gaps_on        = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_gray_pixels();
    test_primaries();
    test_shared_maximum();
    test_hue_wrap();
    test_lightness_split();
    test_random_pixels(500, 1'b0);
    test_random_pixels(1125, 1'b1);

    start_i <= 1'b0;
    while (pending_hls.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[rgb_to_hls_converter_core] OK");
    end else begin
      $display("[rgb_to_hls_converter_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/hlsc_pkg.sv
hdl/hlsc_div.sv
hdl/rgb_to_hls_converter_core.sv
test/rgb_to_hls_converter_core_tb.sv
